/* rtl/lfps_pkg.sv */
// ----------------------------------------------------------------------------
// lfps_pkg
// shared types, widths and constants for the line follower pd steering block
// ----------------------------------------------------------------------------
package lfps_pkg;

    localparam int SENSOR_COUNT = 5;
    localparam int TIME_W       = 16;
    localparam int IDX_W        = $clog2(SENSOR_COUNT);
    localparam int POS_W        = 8;
    localparam int DELTA_W      = POS_W + 1;
    localparam int GAIN_W       = 16;
    localparam int SPEED_W      = 8;
    localparam int CORR_W       = 8;
    localparam int PROD_P_W     = GAIN_W + POS_W;
    localparam int PROD_D_W     = GAIN_W + DELTA_W;
    localparam int SUM_W        = PROD_D_W + 1;
    localparam int FRAC_W       = 8;
    localparam int SHIFTED_W    = SUM_W - FRAC_W;
    localparam int DRIVE_EXT_W  = SPEED_W + 1;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic signed [POS_W-1:0] LINE_WEIGHT [SENSOR_COUNT] =
        '{-8'sd127, -8'sd64, 8'sd0, 8'sd64, 8'sd127};

    localparam logic signed [SHIFTED_W-1:0] CORR_LIMIT_HI = SHIFTED_W'(100);
    localparam logic signed [SHIFTED_W-1:0] CORR_LIMIT_LO = -SHIFTED_W'(100);

    localparam logic signed [GAIN_W-1:0] KP_RESET = 16'sd256;
    localparam logic signed [GAIN_W-1:0] KD_RESET = 16'sd0;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_KP_GAIN     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KD_GAIN     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_SPEED  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RIGHT_SPEED = 2'd3;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp_gain;
        logic signed [GAIN_W-1:0] kd_gain;
        logic [SPEED_W-1:0]       left_base_speed;
        logic [SPEED_W-1:0]       right_base_speed;
    } cfg_t;

    // one classified scan, as it waits between front and back
    typedef struct packed {
        logic [IDX_W-1:0]          line_index;
        logic signed [POS_W-1:0]   position;
        logic signed [DELTA_W-1:0] delta;
    } scan_entry_t;

    typedef struct packed {
        logic        push;
        scan_entry_t entry;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/lfps_scan_if.sv */
// ----------------------------------------------------------------------------
// lfps_scan_if
// scan channel: five sensor decay times with valid and ready
// ----------------------------------------------------------------------------
interface lfps_scan_if;
    logic                        valid;
    logic                        ready;
    logic [lfps_pkg::TIME_W-1:0] sensor_time_0;
    logic [lfps_pkg::TIME_W-1:0] sensor_time_1;
    logic [lfps_pkg::TIME_W-1:0] sensor_time_2;
    logic [lfps_pkg::TIME_W-1:0] sensor_time_3;
    logic [lfps_pkg::TIME_W-1:0] sensor_time_4;

    modport source (
        output valid, sensor_time_0, sensor_time_1, sensor_time_2,
               sensor_time_3, sensor_time_4,
        input  ready
    );
    modport sink (
        input  valid, sensor_time_0, sensor_time_1, sensor_time_2,
               sensor_time_3, sensor_time_4,
        output ready
    );
endinterface

/* rtl/lfps_drive_if.sv */
// ----------------------------------------------------------------------------
// lfps_drive_if
// drive channel: motor drives, correction and chosen sensor with valid and ready
// ----------------------------------------------------------------------------
interface lfps_drive_if;
    logic                               valid;
    logic                               ready;
    logic [lfps_pkg::SPEED_W-1:0]       left_drive;
    logic [lfps_pkg::SPEED_W-1:0]       right_drive;
    logic signed [lfps_pkg::CORR_W-1:0] correction;
    logic [lfps_pkg::IDX_W-1:0]         line_index;

    modport source (
        output valid, left_drive, right_drive, correction, line_index,
        input  ready
    );
    modport sink (
        input  valid, left_drive, right_drive, correction, line_index,
        output ready
    );
endinterface

/* rtl/line_follower_pd_steering.sv */
// ----------------------------------------------------------------------------
// line_follower_pd_steering
// pd steering from a five-sensor reflectance scan, one drive result per scan
//
//   channel | direction | transaction
//   --------+-----------+-------------------------------------------------
//   scan    | in        | sensor_time_0..4, one scan of decay times
//   drive   | out       | left_drive, right_drive, correction, line_index
//   cfg     | in        | cfg_write_en, cfg_index, cfg_data, no read-back
//
// one scan per cycle sustained while drive.ready stays high; from scan accept to
// drive valid a scan passes the queue entry (written at the accept edge), the
// product register and the output register
// the two-entry queue lets the front keep taking scans while the back stalls
// reset clears gains to kp 1.0 and kd 0, base speeds and previous position to 0
// drive.ready low holds the output register, then fills the product stage
// and the queue, and only then drops scan.ready
// ----------------------------------------------------------------------------
module line_follower_pd_steering (
    input  logic                             clk,
    input  logic                             rst_n,
    lfps_scan_if.sink                        scan,
    lfps_drive_if.source                     drive,
    input  logic                             cfg_write_en,
    input  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lfps_pkg::cfg_t          cfg_reg;
    lfps_pkg::cfg_t          cfg_next;
    lfps_pkg::push_t         push;
    lfps_pkg::scan_entry_t   head;
    lfps_pkg::queue_status_t status;
    logic                    pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                lfps_pkg::CFG_KP_GAIN:     cfg_next.kp_gain = $signed(cfg_data);
                lfps_pkg::CFG_KD_GAIN:     cfg_next.kd_gain = $signed(cfg_data);
                lfps_pkg::CFG_LEFT_SPEED:
                    cfg_next.left_base_speed = cfg_data[lfps_pkg::SPEED_W-1:0];
                lfps_pkg::CFG_RIGHT_SPEED:
                    cfg_next.right_base_speed = cfg_data[lfps_pkg::SPEED_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain          <= lfps_pkg::KP_RESET;
            cfg_reg.kd_gain          <= lfps_pkg::KD_RESET;
            cfg_reg.left_base_speed  <= '0;
            cfg_reg.right_base_speed <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lfps_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan),
        .status (status),
        .push   (push)
    );

    lfps_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .status (status)
    );

    lfps_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .status (status),
        .pop    (pop),
        .drive  (drive)
    );

    // queue never takes a scan while full
    assert property (@(posedge clk) disable iff (!rst_n)
        push.push |-> !status.full)
        else $error("scan pushed into full queue");

    // clamp holds on every delivered result
    assert property (@(posedge clk) disable iff (!rst_n)
        drive.valid |-> (drive.correction <= 8'sd100 && drive.correction >= -8'sd100))
        else $error("correction outside clamp range");

    // a positive correction leaves the right drive at its base speed
    assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && drive.correction > 0) |->
            drive.right_drive == cfg_reg.right_base_speed)
        else $error("right drive changed on positive correction");

    // a negative correction leaves the left drive at its base speed
    assert property (@(posedge clk) disable iff (!rst_n)
        (drive.valid && drive.correction < 0) |->
            drive.left_drive == cfg_reg.left_base_speed)
        else $error("left drive changed on negative correction");

endmodule

/* rtl/lfps_front.sv */
// ----------------------------------------------------------------------------
// lfps_front
// accepts scans, picks the darkest sensor and keeps the previous position
// ----------------------------------------------------------------------------
module lfps_front (
    input  logic                    clk,
    input  logic                    rst_n,
    lfps_scan_if.sink               scan,
    input  lfps_pkg::queue_status_t status,
    output lfps_pkg::push_t         push
);

    logic [lfps_pkg::TIME_W-1:0]       times [lfps_pkg::SENSOR_COUNT];
    logic [lfps_pkg::TIME_W-1:0]       best_time;
    logic [lfps_pkg::IDX_W-1:0]        best_index;
    logic signed [lfps_pkg::POS_W-1:0] position;
    logic signed [lfps_pkg::POS_W-1:0] prev_position_reg;
    logic signed [lfps_pkg::POS_W-1:0] prev_position_next;
    logic                              accept;

    assign times[0] = scan.sensor_time_0;
    assign times[1] = scan.sensor_time_1;
    assign times[2] = scan.sensor_time_2;
    assign times[3] = scan.sensor_time_3;
    assign times[4] = scan.sensor_time_4;

    assign scan.ready = !status.full;
    assign accept     = scan.valid && scan.ready;

    // strict compare, so the lowest index wins a tie
    always_comb
    begin
        best_time  = times[0];
        best_index = '0;
        for (int i = 1; i < lfps_pkg::SENSOR_COUNT; i++)
        begin
            if (times[i] > best_time)
            begin
                best_time  = times[i];
                best_index = lfps_pkg::IDX_W'(i);
            end
        end
    end

    assign position = lfps_pkg::LINE_WEIGHT[best_index];

    always_comb
    begin
        push.push             = accept;
        push.entry.line_index = best_index;
        push.entry.position   = position;
        push.entry.delta      = lfps_pkg::DELTA_W'(position)
                              - lfps_pkg::DELTA_W'(prev_position_reg);
        prev_position_next    = accept ? position : prev_position_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_position_reg <= '0;
        end
        else
        begin
            prev_position_reg <= prev_position_next;
        end
    end

endmodule

/* rtl/lfps_queue.sv */
// ----------------------------------------------------------------------------
// lfps_queue
// two-entry queue of classified scans between front and back
// ----------------------------------------------------------------------------
module lfps_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfps_pkg::push_t         push,
    input  logic                    pop,
    output lfps_pkg::scan_entry_t   head,
    output lfps_pkg::queue_status_t status
);

    lfps_pkg::scan_entry_t store_reg [2];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic                  do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head         = store_reg[rd_ptr_reg];
    assign do_pop       = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = push.push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push.push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push)
        begin
            store_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

/* rtl/lfps_back.sv */
// ----------------------------------------------------------------------------
// lfps_back
// pd correction: gain products, then sum, clamp and drive update
// ----------------------------------------------------------------------------
module lfps_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lfps_pkg::cfg_t          cfg,
    input  lfps_pkg::scan_entry_t   head,
    input  lfps_pkg::queue_status_t status,
    output logic                    pop,
    lfps_drive_if.source            drive
);

    // product stage
    logic                                 s1_valid_reg;
    logic                                 s1_valid_next;
    logic signed [lfps_pkg::PROD_P_W-1:0] prod_p_reg;
    logic signed [lfps_pkg::PROD_P_W-1:0] prod_p_next;
    logic signed [lfps_pkg::PROD_D_W-1:0] prod_d_reg;
    logic signed [lfps_pkg::PROD_D_W-1:0] prod_d_next;
    logic [lfps_pkg::IDX_W-1:0]           s1_index_reg;
    logic                                 s1_ready;

    // output stage
    logic                                    out_valid_reg;
    logic                                    out_valid_next;
    logic [lfps_pkg::SPEED_W-1:0]            left_reg;
    logic [lfps_pkg::SPEED_W-1:0]            left_next;
    logic [lfps_pkg::SPEED_W-1:0]            right_reg;
    logic [lfps_pkg::SPEED_W-1:0]            right_next;
    logic signed [lfps_pkg::CORR_W-1:0]      corr_reg;
    logic signed [lfps_pkg::CORR_W-1:0]      corr_next;
    logic [lfps_pkg::IDX_W-1:0]              out_index_reg;
    logic                                    out_ready;

    logic signed [lfps_pkg::POS_W-1:0]       err;
    logic signed [lfps_pkg::SUM_W-1:0]       sum;
    logic signed [lfps_pkg::SHIFTED_W-1:0]   shifted;
    logic signed [lfps_pkg::DRIVE_EXT_W-1:0] corr_ext;
    logic signed [lfps_pkg::DRIVE_EXT_W-1:0] left_ext;
    logic signed [lfps_pkg::DRIVE_EXT_W-1:0] right_ext;

    assign out_ready = !out_valid_reg || drive.ready;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign pop       = s1_ready && !status.empty;

    // target is zero, so the error is the negated position
    assign err = -head.position;

    always_comb
    begin
        prod_p_next = $signed({{(lfps_pkg::PROD_P_W - lfps_pkg::GAIN_W){cfg.kp_gain[lfps_pkg::GAIN_W-1]}},
                               cfg.kp_gain})
                    * $signed({{(lfps_pkg::PROD_P_W - lfps_pkg::POS_W){err[lfps_pkg::POS_W-1]}},
                               err});
        prod_d_next = $signed({{(lfps_pkg::PROD_D_W - lfps_pkg::GAIN_W){cfg.kd_gain[lfps_pkg::GAIN_W-1]}},
                               cfg.kd_gain})
                    * $signed({{(lfps_pkg::PROD_D_W - lfps_pkg::DELTA_W){head.delta[lfps_pkg::DELTA_W-1]}},
                               head.delta});
        s1_valid_next = pop ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_reg);
    end

    always_comb
    begin
        sum     = lfps_pkg::SUM_W'(prod_p_reg) + lfps_pkg::SUM_W'(prod_d_reg);
        // arithmetic shift keeps floor rounding for negative sums
        shifted = sum[lfps_pkg::SUM_W-1:lfps_pkg::FRAC_W];

        if (shifted > lfps_pkg::CORR_LIMIT_HI)
        begin
            corr_next = lfps_pkg::CORR_W'(lfps_pkg::CORR_LIMIT_HI);
        end
        else if (shifted < lfps_pkg::CORR_LIMIT_LO)
        begin
            corr_next = lfps_pkg::CORR_W'(lfps_pkg::CORR_LIMIT_LO);
        end
        else
        begin
            corr_next = shifted[lfps_pkg::CORR_W-1:0];
        end

        corr_ext  = lfps_pkg::DRIVE_EXT_W'(corr_next);
        left_ext  = $signed({1'b0, cfg.left_base_speed});
        right_ext = $signed({1'b0, cfg.right_base_speed});

        if (corr_ext > 0)
        begin
            left_ext = left_ext - corr_ext;
        end
        else
        begin
            right_ext = right_ext + corr_ext;
        end

        left_next  = left_ext[lfps_pkg::DRIVE_EXT_W-1] ? '0
                   : left_ext[lfps_pkg::SPEED_W-1:0];
        right_next = right_ext[lfps_pkg::DRIVE_EXT_W-1] ? '0
                   : right_ext[lfps_pkg::SPEED_W-1:0];

        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prod_p_reg   <= prod_p_next;
            prod_d_reg   <= prod_d_next;
            s1_index_reg <= head.line_index;
        end
        if (out_ready && s1_valid_reg)
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            corr_reg      <= corr_next;
            out_index_reg <= s1_index_reg;
        end
    end

    assign drive.valid       = out_valid_reg;
    assign drive.left_drive  = left_reg;
    assign drive.right_drive = right_reg;
    assign drive.correction  = corr_reg;
    assign drive.line_index  = out_index_reg;

endmodule
